// ===== hdl/fpdf_pkg.sv =====
// Shared types and constants of the fixed-point decimal formatter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fpdf_pkg;

    // Text layout
    localparam int NUM_DIGITS    = 5;
    localparam int DIV_STAGES    = NUM_DIGITS - 1;
    localparam int VALUE_W       = 16;
    localparam int PLACES_W      = 3;
    localparam int CHAR_W        = 8;
    localparam int BCD_W         = 4;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Place count that suppresses the mark, and the last text position
    localparam logic [PLACES_W-1:0] NO_MARK    = 3'd7;
    localparam logic [2:0]          MARK_LIMIT = 3'd6;

    // Divide by ten as multiply by ceil(2^19 / 10), exact for 16-bit operands
    localparam int                 RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 17'd52429;
    localparam int                 RECIP_SHIFT = 19;
    localparam int                 PROD_W      = VALUE_W + RECIP_W;
    localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

    // Configuration register indexes and reset values
    localparam logic CFG_UNSIGNED_MODE = 1'b0;
    localparam logic CFG_MARK_CHAR     = 1'b1;
    localparam logic              UNSIGNED_RESET = 1'b1;
    localparam logic [CHAR_W-1:0] MARK_RESET     = 8'd44;

    // Number in flight: remaining magnitude and the digits peeled off so far.
    // digits[0] is the most significant digit.
    typedef struct packed {
        logic [VALUE_W-1:0]                 mag;
        logic [NUM_DIGITS-1:0][BCD_W-1:0]   digits;
        logic                               neg;
        logic [PLACES_W-1:0]                places;
    } t_digit_word;

endpackage

`default_nettype wire

// ===== hdl/fixed_point_decimal_formatter_top.sv =====
// Top level of the fixed-point decimal formatter: sign stage, divide-by-ten
// pipeline and character serializer. Depends on fpdf_pkg, fpdf_digit_stage
// and fpdf_serializer.
`default_nettype none

// Converts a 16-bit number into sign, five decimal digits and an optional
// decimal mark, sent as ASCII words on the output channel. A number enters a
// six-register pipeline (sign, four divide-by-ten stages, serializer). The
// output channel carries one character per cycle while the receiver does not
// stall, and a number has six characters (no mark) or seven, so sustained
// intake is set by the serializer; up to five more numbers queue in the
// pipeline while it drains. Configuration writes take effect at once and are
// meant for idle periods only.
module fixed_point_decimal_formatter_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_we,
    input  wire                                 i_cfg_index,
    input  wire  [fpdf_pkg::CHAR_W-1:0]         i_cfg_data,
    // number input
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [fpdf_pkg::VALUE_W-1:0]        i_value,
    input  wire  [fpdf_pkg::PLACES_W-1:0]       i_decimal_places,
    // character output
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [fpdf_pkg::CHAR_W-1:0]         o_text_char,
    output logic                                o_last_char
);
    import fpdf_pkg::*;

    logic                 r_unsigned_mode;
    logic [CHAR_W-1:0]    r_mark_char;
    logic                 r_s_valid;
    t_digit_word          r_s_word;
    t_digit_word          n_s_word;
    logic                 w_neg;

    logic                 w_valid [DIV_STAGES+1];
    t_digit_word          w_word  [DIV_STAGES+1];
    logic                 w_stall [DIV_STAGES+1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unsigned_mode <= UNSIGNED_RESET;
            r_mark_char     <= MARK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UNSIGNED_MODE: r_unsigned_mode <= i_cfg_data[0];
                CFG_MARK_CHAR:     r_mark_char     <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Sign stage: split into sign and magnitude
    assign w_neg = !r_unsigned_mode && i_value[VALUE_W-1];

    always_comb begin
        n_s_word        = '0;
        n_s_word.neg    = w_neg;
        n_s_word.mag    = w_neg ? (VALUE_W'(0) - i_value) : i_value;
        n_s_word.places = i_decimal_places;
    end

    assign o_in_stall = r_s_valid && w_stall[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s_word <= n_s_word;
        end
    end

    assign w_valid[0] = r_s_valid;
    assign w_word[0]  = r_s_word;

    // Divide-by-ten stages, least significant digit first
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        fpdf_digit_stage #(
            .DIGIT_IDX (NUM_DIGITS - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_word  (w_word[g]),
            .o_stall (w_stall[g]),
            .o_valid (w_valid[g+1]),
            .o_word  (w_word[g+1]),
            .i_stall (w_stall[g+1])
        );
    end

    // Remaining quotient is the leading digit
    t_digit_word w_final;

    always_comb begin
        w_final           = w_word[DIV_STAGES];
        w_final.digits[0] = w_word[DIV_STAGES].mag[BCD_W-1:0];
    end

    fpdf_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[DIV_STAGES]),
        .i_word      (w_final),
        .o_stall     (w_stall[DIV_STAGES]),
        .i_mark_char (r_mark_char),
        .o_valid     (o_out_valid),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char),
        .i_stall     (i_out_stall)
    );

    // Input stalls only when the sign stage is full
    a_in_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s_valid)
        else $error("input stalled with empty sign stage");

    // Negative magnitude lies between 1 and 32768
    a_neg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && r_s_word.neg) |-> (r_s_word.mag != '0 && r_s_word.mag <= 16'h8000))
        else $error("negative magnitude out of range");

    // After four divisions the leftover fits a single digit
    a_lead_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[DIV_STAGES] |-> (w_word[DIV_STAGES].mag < 16'd10))
        else $error("leading digit overflow");

endmodule

`default_nettype wire

// ===== hdl/fpdf_digit_stage.sv =====
// One pipeline stage of the formatter: peels the lowest decimal digit off
// the magnitude by reciprocal multiplication. Depends on fpdf_pkg.
`default_nettype none

module fpdf_digit_stage #(
    parameter int DIGIT_IDX = fpdf_pkg::NUM_DIGITS - 1
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  fpdf_pkg::t_digit_word   i_word,
    output logic                    o_stall,
    output logic                    o_valid,
    output fpdf_pkg::t_digit_word   o_word,
    input  wire                     i_stall
);
    import fpdf_pkg::*;

    logic                 r_valid;
    t_digit_word          r_word;
    t_digit_word          n_word;
    logic [PROD_W-1:0]    w_prod;
    logic [QUOT_W-1:0]    w_quot;
    logic [VALUE_W-1:0]   w_quot16;
    logic [VALUE_W-1:0]   w_rem16;

    // Quotient and remainder of the magnitude by ten
    assign w_prod   = PROD_W'(i_word.mag) * PROD_W'(RECIP_TEN);
    assign w_quot   = w_prod[PROD_W-1:RECIP_SHIFT];
    assign w_quot16 = VALUE_W'(w_quot);
    assign w_rem16  = i_word.mag - ((w_quot16 << 3) + (w_quot16 << 1));

    always_comb begin
        n_word                   = i_word;
        n_word.mag               = w_quot16;
        n_word.digits[DIGIT_IDX] = w_rem16[BCD_W-1:0];
    end

    // Hold while full and the next stage stalls
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== hdl/fpdf_serializer.sv =====
// Output stage of the formatter: holds one converted number and sends its
// text one character per word, inserting the decimal mark. Depends on fpdf_pkg.
`default_nettype none

module fpdf_serializer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    input  fpdf_pkg::t_digit_word               i_word,
    output logic                                o_stall,
    input  wire  [fpdf_pkg::CHAR_W-1:0]         i_mark_char,
    output logic                                o_valid,
    output logic [fpdf_pkg::CHAR_W-1:0]         o_text_char,
    output logic                                o_last_char,
    input  wire                                 i_stall
);
    import fpdf_pkg::*;

    logic               r_busy;
    logic [2:0]         r_idx;
    t_digit_word        r_word;
    logic               w_has_mark;
    logic [2:0]         w_mark_pos;
    logic [2:0]         w_last_idx;
    logic [2:0]         w_text_idx;
    logic               w_take;
    logic               w_done;
    logic [BCD_W-1:0]   w_digit;

    // Text layout of the held number
    assign w_has_mark = (r_word.places != NO_MARK);
    assign w_mark_pos = MARK_LIMIT - r_word.places;
    assign w_last_idx = w_has_mark ? 3'd6 : 3'd5;
    assign w_text_idx = (w_has_mark && (r_idx > w_mark_pos)) ? (r_idx - 3'd1) : r_idx;

    // Pick the digit behind a text position (position 0 is the sign)
    always_comb begin
        case (w_text_idx)
            3'd1:    w_digit = r_word.digits[0];
            3'd2:    w_digit = r_word.digits[1];
            3'd3:    w_digit = r_word.digits[2];
            3'd4:    w_digit = r_word.digits[3];
            3'd5:    w_digit = r_word.digits[4];
            default: w_digit = '0;
        endcase
    end

    always_comb begin
        if (w_has_mark && (r_idx == w_mark_pos)) begin
            o_text_char = i_mark_char;
        end else if (w_text_idx == 3'd0) begin
            o_text_char = r_word.neg ? CHAR_MINUS : CHAR_PLUS;
        end else begin
            o_text_char = CHAR_ZERO + CHAR_W'(w_digit);
        end
    end

    assign o_valid     = r_busy;
    assign o_last_char = (r_idx == w_last_idx);
    assign w_take      = r_busy && !i_stall;
    assign w_done      = w_take && o_last_char;

    // Take a new number once the last character of the held one leaves
    assign o_stall = r_busy && !w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (!o_stall && i_valid) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (w_take) begin
            r_idx  <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench of fixed_point_decimal_formatter_top: directed table, then random
// numbers under several register settings, with bursty input and a stalling receiver.
// Depends on fpdf_pkg and the block's RTL only.

module testbench;
    import fpdf_pkg::*;

    // One expected character word
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_word;

    // One row of the directed table; text_len of zero leaves the row to the predictor
    typedef struct packed {
        logic                unsigned_mode;
        logic [CHAR_W-1:0]   mark;
        logic [VALUE_W-1:0]  value;
        logic [PLACES_W-1:0] places;
        logic [2:0]          text_len;
        logic [55:0]         text;
    } t_number_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [CHAR_W-1:0]   i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [VALUE_W-1:0]  i_value;
    logic [PLACES_W-1:0] i_decimal_places;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [CHAR_W-1:0]   o_text_char;
    logic                o_last_char;

    // Local copy of the registers
    logic                cfg_unsigned;
    logic [CHAR_W-1:0]   cfg_mark;

    t_char_word  pending_chars[$];
    t_number_row number_table[$];
    int          error_count;
    int          numbers_sent;
    int          chars_checked;
    int          burst_left;
    int          stall_cycle;
    int          stall_mode;

    fixed_point_decimal_formatter_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_value          (i_value),
        .i_decimal_places (i_decimal_places),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_text_char      (o_text_char),
        .o_last_char      (o_last_char)
    );

    // Clock, period 4
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Queue the characters of one number under the current registers
    function automatic void predict_text(input logic [VALUE_W-1:0] v,
                                         input logic [PLACES_W-1:0] places);
        logic [CHAR_W-1:0] text [0:5];
        logic [CHAR_W-1:0] seq [0:6];
        int unsigned       mag;
        int                n;
        int                pos;
        t_char_word        w;

        mag = 32'(v);
        text[0] = CHAR_PLUS;
        // Negative in signed mode: print the magnitude
        if (!cfg_unsigned && v[VALUE_W-1]) begin
            text[0] = CHAR_MINUS;
            mag = (32'h10000 - 32'(v)) & 32'hFFFF;
        end
        for (pos = 5; pos >= 1; pos--) begin
            text[pos] = CHAR_ZERO + CHAR_W'(mag % 10);
            mag = mag / 10;
        end
        n = 0;
        for (pos = 0; pos <= 6; pos++) begin
            if (places != NO_MARK && pos == 6 - places) begin
                seq[n] = cfg_mark;
                n++;
            end
            if (pos < 6) begin
                seq[n] = text[pos];
                n++;
            end
        end
        for (pos = 0; pos < n; pos++) begin
            w.ch = seq[pos];
            w.last = (pos == n - 1);
            pending_chars.push_back(w);
        end
    endfunction

    // Queue a hand-written expected text, first character in the top byte
    function automatic void queue_typed_text(input logic [2:0] len, input logic [55:0] text);
        t_char_word w;
        int         k;

        for (k = 0; k < len; k++) begin
            w.ch = text[8*(len-1-k) +: 8];
            w.last = (k == len - 1);
            pending_chars.push_back(w);
        end
    endfunction

    function automatic void add_row(input logic mode, input logic [CHAR_W-1:0] mark,
                                    input logic [VALUE_W-1:0] v, input logic [PLACES_W-1:0] p,
                                    input logic [2:0] len, input logic [55:0] text);
        t_number_row r;

        r.unsigned_mode = mode;
        r.mark = mark;
        r.value = v;
        r.places = p;
        r.text_len = len;
        r.text = text;
        number_table.push_back(r);
    endfunction

    // Random value, biased toward digit and sign boundaries
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;

        v = VALUE_W'($urandom);
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 11))
                    0:  v = 16'd0;
                    1:  v = 16'd1;
                    2:  v = 16'd9;
                    3:  v = 16'd10;
                    4:  v = 16'd99;
                    5:  v = 16'd100;
                    6:  v = 16'd9999;
                    7:  v = 16'd10000;
                    8:  v = 16'd32767;
                    9:  v = 16'd32768;
                    10: v = 16'd32769;
                    default: v = 16'd65535;
                endcase
            end
            1: v = VALUE_W'($urandom_range(0, 99));
            default: ;
        endcase
        return v;
    endfunction

    // Drain the block, then write both registers
    task automatic set_config(input logic mode, input logic [CHAR_W-1:0] mark);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_UNSIGNED_MODE;
        i_cfg_data  <= {7'd0, mode};
        @(posedge i_clk);
        cfg_unsigned = mode;
        i_cfg_index <= CFG_MARK_CHAR;
        i_cfg_data  <= mark;
        @(posedge i_clk);
        cfg_mark = mark;
        i_cfg_we <= 1'b0;
    endtask

    // Insert a random gap at the end of each burst
    task automatic pace_sender();
        int gap;

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Offer one number word and hold it until accepted; valid stays high afterwards
    task automatic send_number(input logic [VALUE_W-1:0] v, input logic [PLACES_W-1:0] p,
                               input logic [2:0] typed_len, input logic [55:0] typed_text);
        i_in_valid       <= 1'b1;
        i_value          <= v;
        i_decimal_places <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        numbers_sent++;
        if (typed_len != 0) begin
            queue_typed_text(typed_len, typed_text);
        end else begin
            predict_text(v, p);
        end
    endtask

    // Receiver stall pattern: switch at random between four styles
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 64 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_cycle % 8 < 3);
        endcase
    end

    // Compare each accepted character word with the oldest expectation
    always @(posedge i_clk) begin
        t_char_word w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected word char=%h last=%b", $time, o_text_char,
                         o_last_char);
                error_count++;
            end else begin
                w = pending_chars.pop_front();
                chars_checked++;
                if (o_text_char !== w.ch) begin
                    $display("%0t: text_char expected %h actual %h", $time, w.ch,
                             o_text_char);
                    error_count++;
                end
                if (o_last_char !== w.last) begin
                    $display("%0t: last_char expected %b actual %b", $time, w.last,
                             o_last_char);
                    error_count++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #400000;
        $display("fixed_point_decimal_formatter_top verification failed");
        $finish;
    end

    // Main sequence
    initial begin
        t_number_row row;
        int          phase;
        int          idx;
        logic        mode;
        logic [7:0]  mark;

        error_count   = 0;
        numbers_sent  = 0;
        chars_checked = 0;
        burst_left    = 0;
        stall_cycle   = 0;
        stall_mode    = 0;
        cfg_unsigned  = UNSIGNED_RESET;
        cfg_mark      = MARK_RESET;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_UNSIGNED_MODE;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_value          <= '0;
        i_decimal_places <= '0;
        i_out_stall      <= 1'b0;

        // Reset settings: unsigned, comma
        add_row(1'b1, 8'd44, 16'd0,     3'd7, 3'd6, "+00000");
        add_row(1'b1, 8'd44, 16'd65535, 3'd0, 3'd7, "+65535,");
        add_row(1'b1, 8'd44, 16'd12345, 3'd2, 3'd7, "+123,45");
        add_row(1'b1, 8'd44, 16'd1,     3'd6, 3'd7, ",+00001");
        add_row(1'b1, 8'd44, 16'd32768, 3'd5, 3'd7, "+,32768");
        add_row(1'b1, 8'd44, 16'd54321, 3'd1, 3'd0, "");
        add_row(1'b1, 8'd44, 16'd9,     3'd3, 3'd0, "");
        add_row(1'b1, 8'd44, 16'd40000, 3'd4, 3'd0, "");
        // Signed, period
        add_row(1'b0, 8'd46, 16'd32768, 3'd7, 3'd6, "-32768");
        add_row(1'b0, 8'd46, 16'd65535, 3'd3, 3'd7, "-00.001");
        add_row(1'b0, 8'd46, 16'd32767, 3'd0, 3'd7, "+32767.");
        add_row(1'b0, 8'd46, 16'd0,     3'd6, 3'd7, ".+00000");
        add_row(1'b0, 8'd46, 16'd1,     3'd7, 3'd6, "+00001");
        add_row(1'b0, 8'd46, 16'd65534, 3'd2, 3'd0, "");
        add_row(1'b0, 8'd46, 16'd40000, 3'd5, 3'd0, "");
        add_row(1'b0, 8'd46, 16'd12345, 3'd4, 3'd0, "");
        // Signed, mark all zeros
        add_row(1'b0, 8'd0,  16'd32768, 3'd1, 3'd0, "");
        add_row(1'b0, 8'd0,  16'd100,   3'd3, 3'd0, "");
        // Unsigned, mark all ones
        add_row(1'b1, 8'd255, 16'd65535, 3'd6, 3'd0, "");
        add_row(1'b1, 8'd255, 16'd10000, 3'd0, 3'd0, "");
        add_row(1'b1, 8'd255, 16'h5555,  3'd7, 3'd0, "");
        add_row(1'b1, 8'd255, 16'hAAAA,  3'd4, 3'd0, "");

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (idx = 0; idx < number_table.size(); idx++) begin
            row = number_table[idx];
            if (row.unsigned_mode != cfg_unsigned || row.mark != cfg_mark) begin
                set_config(row.unsigned_mode, row.mark);
            end
            pace_sender();
            send_number(row.value, row.places, row.text_len, row.text);
        end

        // Random numbers in six register phases
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin mode = 1'b0; mark = 8'd0;   end
                1: begin mode = 1'b1; mark = 8'd255; end
                2: begin mode = 1'b0; mark = 8'd44;  end
                default: begin
                    mode = 1'($urandom_range(0, 1));
                    mark = 8'($urandom_range(0, 255));
                end
            endcase
            set_config(mode, mark);
            for (idx = 0; idx < 21; idx++) begin
                pace_sender();
                send_number(pick_value(), PLACES_W'($urandom_range(0, 7)), 3'd0, 56'd0);
            end
        end

        // Drain and let the pipeline settle
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d numbers under 10 register settings, checked %0d characters",
                 numbers_sent, chars_checked);
        $display("with %0d mismatches", error_count);
        if (error_count == 0) begin
            $display("fixed_point_decimal_formatter_top verification clean");
        end else begin
            $display("fixed_point_decimal_formatter_top verification failed");
        end
        $finish;
    end

endmodule
